// ===== rtl/rhhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhhs_pkg
// Shared types and constants for the Robin Hood hash set.
// ----------------------------------------------------------------------------
package rhhs_pkg;

    localparam int unsigned SLOTS_DEF     = 256;
    localparam int unsigned KEY_WIDTH_DEF = 32;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request, set position to home slot (slot 0 for a clear)
        logic rd;         // issue memory read at position
        logic ins_wr;     // write carried entry at position (swap or place)
        logic ins_adv;    // advance insert probe after a read
        logic find_adv;   // advance lookup probe
        logic found;      // record found slot
        logic rm_clear;   // empty the found slot, decrement count
        logic sh_wr;      // write shifted entry to previous slot
        logic sh_adv;     // advance shift pointers
        logic clr_wr;     // clear sweep write
        logic clr_adv;    // clear sweep advance
        logic resp_load;  // load result register
        logic [1:0] resp_status;
    } rhhs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       count_zero;
        logic       full;
        logic       rd_empty;    // read slot empty
        logic       rd_match;    // read key matches request key
        logic       rd_shorter;  // resident probe length is shorter than ours
        logic       rd_le1;      // resident probe length <= 1
        logic       turn_done;   // a full turn has been probed
        logic       clr_last;    // clear sweep at last slot
    } rhhs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rhhs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhhs_ctrl
// Sequencer for lookup, insert, remove and clear requests.
// ----------------------------------------------------------------------------
module rhhs_ctrl
    import rhhs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output rhhs_cmd_t      cmd,
    input  wire rhhs_sts_t sts
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DISP   = 9'b000000010,
        S_FRD    = 9'b000000100,
        S_FCHK   = 9'b000001000,
        S_IRD    = 9'b000010000,
        S_ICHK   = 9'b000100000,
        S_SRD    = 9'b001000000,
        S_SCHK   = 9'b010000000,
        S_CLR    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    assign m_valid = mv_reg;
    // A new item is taken once the previous result has been or is being handed over.
    assign s_ready = (state_reg == S_IDLE) && (!mv_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.req_type)
                    REQ_LOOKUP, REQ_REMOVE: begin
                        if (sts.count_zero) begin
                            cmd.resp_load   = 1'b1;
                            cmd.resp_status = ST_NOTFOUND;
                            mv_next         = 1'b1;
                            state_next      = S_IDLE;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_FRD;
                        end
                    end
                    REQ_INSERT: begin
                        if (sts.full) begin
                            cmd.resp_load   = 1'b1;
                            cmd.resp_status = ST_FULL;
                            mv_next         = 1'b1;
                            state_next      = S_IDLE;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_IRD;
                        end
                    end
                    default: begin
                        state_next = S_CLR;
                    end
                endcase
            end
            S_FRD: state_next = S_FCHK;
            S_FCHK: begin
                if (sts.rd_empty) begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_status = ST_NOTFOUND;
                    mv_next         = 1'b1;
                    state_next      = S_IDLE;
                end else if (sts.rd_match) begin
                    cmd.found = 1'b1;
                    if (sts.req_type == REQ_REMOVE) begin
                        cmd.rm_clear = 1'b1;
                        state_next   = S_SRD;
                    end else begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_status = ST_OK;
                        mv_next         = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else if (sts.rd_shorter || sts.turn_done) begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_status = ST_NOTFOUND;
                    mv_next         = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.find_adv = 1'b1;
                    state_next   = S_FRD;
                end
            end
            S_IRD: state_next = S_ICHK;
            S_ICHK: begin
                cmd.ins_wr = sts.rd_empty || sts.rd_shorter;
                if (sts.rd_empty) begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_status = ST_OK;
                    mv_next         = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.ins_adv = 1'b1;
                    state_next  = S_IRD;
                end
            end
            S_SRD: state_next = S_SCHK;
            S_SCHK: begin
                if (sts.rd_le1 || sts.turn_done) begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_status = ST_OK;
                    mv_next         = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    cmd.sh_wr  = 1'b1;
                    cmd.sh_adv = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_CLR: begin
                cmd.clr_wr  = 1'b1;
                cmd.clr_adv = 1'b1;
                if (sts.clr_last) begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_status = ST_OK;
                    mv_next         = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // The read for the next probe step is issued with each advance.
        if (cmd.find_adv || cmd.ins_adv || cmd.sh_adv || cmd.rm_clear) begin
            cmd.rd = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rhhs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhhs_dp
// Slot memories, probe pointers, carried entry and result registers.
// ----------------------------------------------------------------------------
module rhhs_dp
    import rhhs_pkg::*;
#(
    parameter int unsigned SLOTS     = SLOTS_DEF,
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_hash_value,
    input  wire rhhs_cmd_t   cmd,
    output rhhs_sts_t        sts,
    output logic [1:0]       m_status,
    output logic [7:0]       m_slot,
    output logic [8:0]       m_entry_total
);

    localparam int unsigned AW  = $clog2(SLOTS);
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned PW  = $clog2(SLOTS + 1);
    localparam int unsigned MARGIN_RAW = SLOTS / 10;
    localparam int unsigned MARGIN = (MARGIN_RAW < 1) ? 1 : MARGIN_RAW;
    localparam int unsigned FULL_AT = SLOTS - MARGIN;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    // Key memory; its contents are undefined until written.
    logic [KEY_WIDTH-1:0] key_mem [SLOTS];
    // Probe lengths, zero meaning empty. Cleared by a sweep on clear requests;
    // valid bits stand for the reset value.
    logic [PW-1:0]        psl_mem [SLOTS];
    logic [SLOTS-1:0]     vld_reg;

    logic [1:0]           req_reg;
    logic [KEY_WIDTH-1:0] rkey_reg;
    logic [AW-1:0]        pos_reg, prev_reg;
    logic [KEY_WIDTH-1:0] carry_reg;
    logic [PW-1:0]        cpsl_reg;      // our probe length
    logic [AW:0]          steps_reg;
    logic                 placed_reg;
    logic [AW-1:0]        found_reg;
    logic [CW-1:0]        count_reg;
    logic [KEY_WIDTH-1:0] rdk_reg;
    logic [PW-1:0]        rdp_raw_reg;
    logic                 rdv_reg;
    logic [PW-1:0]        rdp;
    logic [1:0]           st_reg;
    logic [7:0]           slot_reg;

    logic [AW-1:0] pos_inc;
    logic [AW-1:0] home;

    // The cleared slot after a shifted entry moves back: the shift writes
    // the previous slot, and the slot it came from is filled by the next shift
    // or emptied at the end of the remove.
    logic [AW-1:0] hole_reg;
    logic          hole_pend_reg;
    logic          hole_fix;

    assign pos_inc = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign home    = AW'(s_hash_value % SLOTS);
    assign rdp     = rdv_reg ? rdp_raw_reg : '0;

    assign sts.req_type   = req_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (32'(count_reg) >= FULL_AT);
    assign sts.rd_empty   = (rdp == '0);
    assign sts.rd_match   = (rdk_reg == rkey_reg);
    assign sts.rd_shorter = (cpsl_reg > rdp);
    assign sts.rd_le1     = (rdp <= PW'(1));
    assign sts.turn_done  = (steps_reg >= (AW + 1)'(SLOTS - 1));
    assign sts.clr_last   = (pos_reg == LAST);

    // A source slot left behind at the end of a shift is emptied when the
    // result is loaded.
    assign hole_fix = cmd.resp_load && hole_pend_reg && (req_reg == REQ_REMOVE);

    // Address of the next read: the slot after the current one on an
    // advance, otherwise the current slot.
    function automatic logic [AW-1:0] rd_addr();
        if (cmd.find_adv || cmd.ins_adv || cmd.sh_adv || cmd.rm_clear) begin
            return pos_inc;
        end
        return pos_reg;
    endfunction

    function automatic logic [AW-1:0] found_next_pos();
        return pos_inc;
    endfunction

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdk_reg     <= key_mem[cmd.rm_clear ? found_next_pos() : rd_addr()];
            rdp_raw_reg <= psl_mem[rd_addr()];
        end
        if (cmd.ins_wr) begin
            key_mem[pos_reg] <= carry_reg;
            psl_mem[pos_reg] <= cpsl_reg;
        end else if (cmd.sh_wr) begin
            key_mem[prev_reg] <= rdk_reg;
            psl_mem[prev_reg] <= rdp - 1'b1;
        end else if (cmd.rm_clear) begin
            psl_mem[pos_reg] <= '0;
        end else if (cmd.clr_wr) begin
            psl_mem[pos_reg] <= '0;
        end else if (hole_fix) begin
            psl_mem[hole_reg] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
        end else begin
            if (cmd.rd) begin
                rdv_reg <= vld_reg[rd_addr()];
            end
            if (cmd.ins_wr) begin
                vld_reg[pos_reg] <= 1'b1;
            end
            if (cmd.sh_wr) begin
                vld_reg[prev_reg] <= 1'b1;
            end
            if (cmd.ins_wr && sts.rd_empty) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.rm_clear) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.clr_wr && sts.clr_last) begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_req_type;
            rkey_reg   <= KEY_WIDTH'(s_key);
            carry_reg  <= KEY_WIDTH'(s_key);
            pos_reg    <= (s_req_type == REQ_CLEAR) ? '0 : home;
            cpsl_reg   <= PW'(1);
            steps_reg  <= '0;
            placed_reg <= 1'b0;
        end
        if (cmd.find_adv) begin
            pos_reg   <= pos_inc;
            cpsl_reg  <= cpsl_reg + 1'b1;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.ins_adv) begin
            pos_reg <= pos_inc;
            if (sts.rd_shorter) begin
                carry_reg <= rdk_reg;
                cpsl_reg  <= rdp + 1'b1;
                if (!placed_reg) begin
                    found_reg  <= pos_reg;
                    placed_reg <= 1'b1;
                end
            end else begin
                cpsl_reg <= cpsl_reg + 1'b1;
            end
        end
        if (cmd.ins_wr && sts.rd_empty && !placed_reg) begin
            found_reg <= pos_reg;
        end
        if (cmd.found) begin
            found_reg <= pos_reg;
        end
        if (cmd.rm_clear) begin
            prev_reg  <= pos_reg;
            pos_reg   <= pos_inc;
            steps_reg <= (AW + 1)'(1);
        end
        if (cmd.sh_adv) begin
            prev_reg  <= pos_reg;
            pos_reg   <= pos_inc;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.clr_adv) begin
            pos_reg <= pos_inc;
        end
        if (cmd.resp_load) begin
            st_reg <= cmd.resp_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hole_pend_reg <= 1'b0;
        end else begin
            if (cmd.sh_wr) begin
                hole_pend_reg <= 1'b1;
                hole_reg      <= pos_reg;
            end else if (cmd.load) begin
                hole_pend_reg <= 1'b0;
            end
        end
    end

    // Result slot: found or first placed, zero for not found, full or clear.
    logic [7:0] res_slot;
    always_comb begin
        res_slot = '0;
        if (cmd.resp_status == ST_OK && req_reg != REQ_CLEAR) begin
            if (req_reg == REQ_INSERT) begin
                res_slot = placed_reg ? 8'(found_reg) : 8'(pos_reg);
            end else if (req_reg == REQ_LOOKUP) begin
                res_slot = 8'(pos_reg);
            end else begin
                res_slot = 8'(found_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            slot_reg <= res_slot;
        end
    end

    assign m_status      = st_reg;
    assign m_slot        = slot_reg;
    assign m_entry_total = 9'(count_reg);

endmodule
`default_nettype wire

// ===== rtl/robin_hood_hash_set_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// robin_hood_hash_set_core
// Fixed-size Robin Hood hash set with backward-shift deletion.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_ channel carries a request type (lookup,
// insert, remove or clear), a key and the key's precomputed hash. Exactly
// one result item leaves on the m_ channel per request, carrying a status,
// the slot found or first placed, and the number of stored entries.
// Each request is accepted and dispatched, then each probed slot is read
// and compared; the slot memories have one read port, so a probe step is
// a read state followed by a compare state. A remove also checks the slot
// after the found one and shifts each displaced entry back by one slot.
// A clear sweeps the probe-length memory one slot a cycle, from slot 0 to the last.
// One item is worked on at a time; the next item is accepted once the
// previous result is taken or is being taken in the same cycle.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the result holds on the m_ ports and no new item is accepted.
// ----------------------------------------------------------------------------
module robin_hood_hash_set_core
    import rhhs_pkg::*;
#(
    parameter int unsigned SLOTS     = SLOTS_DEF,
    parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_hash_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_slot,
    output logic [8:0]       m_entry_total
);

    rhhs_cmd_t cmd;
    rhhs_sts_t sts;

    // Sequencer: decides each probe step from the datapath's compares.
    rhhs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: slot memories, probe pointer, carried entry and results.
    rhhs_dp #(
        .SLOTS     (SLOTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_hash_value  (s_hash_value),
        .cmd           (cmd),
        .sts           (sts),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_entry_total (m_entry_total)
    );

endmodule
`default_nettype wire
